// File: rtl/ciaa_pkg.sv
// ============================================================================
// ciaa_pkg - shared definitions for the checked integer accumulator ALU
// Operation and status codes, default widths, and the control and status
// bundles exchanged between the sequencer and the shared arithmetic unit.
// ============================================================================
package ciaa_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int OPERAND_WIDTH  = 32;
    localparam int RESULT_WIDTH   = 32;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_REM   = 3'd4,
        OP_NEG   = 3'd5,
        OP_POW   = 3'd6,
        OP_CLEAR = 3'd7
    } ciaa_op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_UNF  = 2'd2,
        ST_DIV0 = 2'd3
    } ciaa_status_t;

    // Sequencer to arithmetic unit.
    typedef struct packed {
        logic start;
        logic div_mode;
    } ciaa_unit_ctl_t;

    // Arithmetic unit to sequencer.
    typedef struct packed {
        logic done;
        logic ovf;
    } ciaa_unit_sts_t;

endpackage

// File: rtl/ciaa_muldiv_unit.sv
// ============================================================================
// ciaa_muldiv_unit - bit-serial magnitude multiplier and restoring divider
// One adder of DATA_WIDTH + 2 bits is used once per cycle while the unit is
// busy, either as a shift-add multiplier with sticky overflow detection or
// as a restoring divider.
// ============================================================================
module ciaa_muldiv_unit
    import ciaa_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ciaa_unit_ctl_t        ctl,
    input  logic [DATA_WIDTH-1:0] x,
    input  logic [DATA_WIDTH-1:0] y,
    output ciaa_unit_sts_t        sts,
    output logic [DATA_WIDTH-1:0] lo,
    output logic [DATA_WIDTH-1:0] quo
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    logic                  busy_reg;
    logic                  done_reg;
    logic                  div_reg;
    logic                  ovf_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DATA_WIDTH-1:0] x_reg;
    logic [DATA_WIDTH-1:0] y_reg;
    logic [DATA_WIDTH:0]   part_reg;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   addend;
    logic [DATA_WIDTH+1:0] sum;
    logic                  qbit;
    logic [DATA_WIDTH:0]   part_next;
    logic                  ovf_next;
    logic [DATA_WIDTH-1:0] y_next;

    // The multiplier is scanned from its top bit, so the partial product only
    // grows; once it passes the largest positive value the result overflows.
    always_comb begin
        shifted = {part_reg[DATA_WIDTH-1:0], div_reg ? y_reg[DATA_WIDTH-1] : 1'b0};
        if (div_reg) begin
            addend = ~{1'b0, x_reg};
        end else if (y_reg[DATA_WIDTH-1]) begin
            addend = {1'b0, x_reg};
        end else begin
            addend = '0;
        end
        sum       = {1'b0, shifted} + {1'b0, addend} + (DATA_WIDTH+2)'(div_reg);
        qbit      = div_reg & sum[DATA_WIDTH+1];
        part_next = (div_reg && !qbit) ? shifted : sum[DATA_WIDTH:0];
        ovf_next  = ovf_reg | (!div_reg & (sum[DATA_WIDTH] | sum[DATA_WIDTH-1]));
        y_next    = {y_reg[DATA_WIDTH-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DATA_WIDTH - 1);
                div_reg  <= ctl.div_mode;
                x_reg    <= x;
                y_reg    <= y;
                part_reg <= '0;
                ovf_reg  <= 1'b0;
            end else if (busy_reg) begin
                part_reg <= part_next;
                ovf_reg  <= ovf_next;
                y_reg    <= y_next;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    assign sts.done = done_reg;
    assign sts.ovf  = ovf_reg;
    assign lo       = part_reg[DATA_WIDTH-1:0];
    assign quo      = y_reg;

`ifndef ASSERT_OFF
    // A new operation must never be started on top of one in progress.
    a_no_restart_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |-> !busy_reg)
        else $error("muldiv unit started while busy");

    // Completion follows the final iteration of a running operation.
    a_done_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> ($past(busy_reg) && ($past(cnt_reg) == '0)))
        else $error("muldiv done without a final iteration");

    // The completion flag is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("muldiv done held for more than one cycle");
`endif

endmodule

// File: rtl/checked_integer_accumulator_alu_unit.sv
// Add, subtract, negate, clear and division by zero finish in the decode state; multiply,
// divide and remainder otherwise make one pass through the shared unit; power makes one
// multiply pass per exponent step, at most DATA_WIDTH - 1 passes in all.
// One transaction is in flight at a time: a new one is accepted only once the last
// is in the output register. The shared multiply/divide unit works one bit per cycle.
// Reset (aresetn low, synchronous) clears the accumulator to zero and empties the output.
// ============================================================================
// checked_integer_accumulator_alu_unit - overflow-checked accumulator ALU
// A signed accumulator takes one operation and one operand per transaction
// and returns the new value together with an ok, overflow, underflow or
// divide-by-zero status.
// ============================================================================
module checked_integer_accumulator_alu_unit
    import ciaa_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [2:0]                      s_req_type,
    input  logic signed [OPERAND_WIDTH-1:0] s_operand,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [RESULT_WIDTH-1:0]  m_acc_value,
    output logic [1:0]                      m_status
);

    localparam logic [DATA_WIDTH-1:0] SIGN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] ONE_VAL  = DATA_WIDTH'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_MULDIV,
        S_DONE
    } state_t;

    state_t                    state_reg;
    ciaa_op_t                  op_reg;
    logic [DATA_WIDTH-1:0]     acc_reg;
    logic [DATA_WIDTH-1:0]     b_reg;
    logic [DATA_WIDTH-1:0]     mn_reg;
    logic [DATA_WIDTH-1:0]     e_reg;
    logic [DATA_WIDTH-1:0]     res_reg;
    ciaa_status_t              st_reg;
    logic                      ng_reg;
    logic                      ustart_reg;
    logic                      udiv_reg;
    logic [DATA_WIDTH-1:0]     ux_reg;
    logic [DATA_WIDTH-1:0]     uy_reg;
    logic                      m_valid_reg;
    logic [RESULT_WIDTH-1:0]   m_acc_value_reg;
    ciaa_status_t              m_status_reg;

    logic [DATA_WIDTH-1:0]     b_in;
    logic                      sa;
    logic                      sb;
    logic [DATA_WIDTH-1:0]     neg_acc;
    logic [DATA_WIDTH-1:0]     neg_b;
    logic [DATA_WIDTH-1:0]     ma;
    logic [DATA_WIDTH-1:0]     mb;
    logic                      is_sub;
    logic [DATA_WIDTH-1:0]     addsub;
    logic                      as_ovf;
    logic                      as_unf;
    logic [DATA_WIDTH-1:0]     u_mag;
    logic [DATA_WIDTH-1:0]     u_signed;
    logic                      out_load;

    ciaa_unit_ctl_t            u_ctl;
    ciaa_unit_sts_t            u_sts;
    logic [DATA_WIDTH-1:0]     u_lo;
    logic [DATA_WIDTH-1:0]     u_quo;

    // The operand is sign-extended from its 32-bit port and then taken at the
    // accumulator width; a size cast of a signed value does exactly that.
    assign b_in = DATA_WIDTH'(s_operand);

    // Operand decode, shared by every operation in the decode cycle. The
    // magnitude of the most negative value is its own bit pattern, read as
    // unsigned, which is what the magnitude arithmetic expects.
    always_comb begin
        sa      = acc_reg[DATA_WIDTH-1];
        sb      = b_reg[DATA_WIDTH-1];
        neg_acc = -acc_reg;
        neg_b   = -b_reg;
        ma      = sa ? neg_acc : acc_reg;
        mb      = sb ? neg_b : b_reg;
        // One adder serves add and subtract. A wrap shows as a result whose
        // sign disagrees with two operands of equal effective sign, and this
        // also catches a wrapped sum that happens to be zero.
        is_sub  = (op_reg == OP_SUB);
        addsub  = acc_reg + (is_sub ? ~b_reg : b_reg) + DATA_WIDTH'(is_sub);
        as_ovf  = !sa && (sb == is_sub) && addsub[DATA_WIDTH-1];
        as_unf  = sa && (sb != is_sub) && !addsub[DATA_WIDTH-1];
    end

    // The unit delivers magnitudes; the sign goes on products and quotients only.
    always_comb begin
        u_mag    = (op_reg == OP_DIV) ? u_quo : u_lo;
        u_signed = ng_reg ? -u_mag : u_mag;
    end

    assign u_ctl.start    = ustart_reg;
    assign u_ctl.div_mode = udiv_reg;

    ciaa_muldiv_unit #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (u_ctl),
        .x       (ux_reg),
        .y       (uy_reg),
        .sts     (u_sts),
        .lo      (u_lo),
        .quo     (u_quo)
    );

    // A finished result moves to the output register as soon as the
    // register is empty or being emptied in the same cycle.
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign s_ready  = (state_reg == S_IDLE);

    // Sequencer. Simple operations and division by zero finish in the decode
    // cycle. Multiply, divide and remainder otherwise make one pass through
    // the shared unit. Power makes one multiply pass per exponent step and
    // stops early on overflow; with a base magnitude of two or more that
    // happens within DATA_WIDTH - 1 passes, and bases of magnitude zero or one
    // never enter the loop. Every error path returns the old accumulator, so
    // the accumulator is written unconditionally when the result is handed over.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
            ustart_reg  <= 1'b0;
        end else begin
            ustart_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= ciaa_op_t'(s_req_type);
                        b_reg     <= b_in;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    res_reg   <= acc_reg;
                    st_reg    <= ST_OK;
                    ng_reg    <= sa ^ sb;
                    state_reg <= S_DONE;
                    case (op_reg)
                        OP_ADD, OP_SUB: begin
                            if (as_ovf) begin
                                st_reg <= ST_OVF;
                            end else if (as_unf) begin
                                st_reg <= ST_UNF;
                            end else begin
                                res_reg <= addsub;
                            end
                        end
                        OP_MUL: begin
                            ux_reg     <= ma;
                            uy_reg     <= mb;
                            udiv_reg   <= 1'b0;
                            ustart_reg <= 1'b1;
                            state_reg  <= S_MULDIV;
                        end
                        OP_DIV, OP_REM: begin
                            if (mb == '0) begin
                                st_reg <= ST_DIV0;
                            end else begin
                                ux_reg     <= mb;
                                uy_reg     <= ma;
                                udiv_reg   <= 1'b1;
                                ustart_reg <= 1'b1;
                                state_reg  <= S_MULDIV;
                            end
                        end
                        OP_NEG: begin
                            if (acc_reg == SIGN_VAL) begin
                                st_reg <= ST_OVF;
                            end else begin
                                res_reg <= neg_acc;
                            end
                        end
                        OP_POW: begin
                            ng_reg <= sa & b_reg[0];
                            if (sb) begin
                                res_reg <= '0;
                            end else if (b_reg == '0) begin
                                res_reg <= ONE_VAL;
                            end else if (ma <= ONE_VAL) begin
                                // Base of 0, 1 or -1: only minus one to an even
                                // power changes the value.
                                res_reg <= (sa && !b_reg[0]) ? neg_acc : acc_reg;
                            end else begin
                                mn_reg     <= ma;
                                e_reg      <= b_reg;
                                ux_reg     <= ma;
                                uy_reg     <= ONE_VAL;
                                udiv_reg   <= 1'b0;
                                ustart_reg <= 1'b1;
                                state_reg  <= S_MULDIV;
                            end
                        end
                        OP_CLEAR: begin
                            res_reg <= '0;
                        end
                        default: begin
                            res_reg <= '0;
                        end
                    endcase
                end
                S_MULDIV: begin
                    if (u_sts.done) begin
                        res_reg   <= acc_reg;
                        st_reg    <= ST_OK;
                        state_reg <= S_DONE;
                        case (op_reg)
                            OP_MUL: begin
                                if (u_sts.ovf) begin
                                    st_reg <= ST_OVF;
                                end else begin
                                    res_reg <= u_signed;
                                end
                            end
                            OP_DIV: begin
                                // Only the most negative value over minus one
                                // gives a positive quotient out of range.
                                if (!ng_reg && u_quo[DATA_WIDTH-1]) begin
                                    st_reg <= ST_OVF;
                                end else begin
                                    res_reg <= u_signed;
                                end
                            end
                            OP_REM: begin
                                res_reg <= u_lo;
                            end
                            OP_POW: begin
                                if (u_sts.ovf) begin
                                    st_reg <= ST_OVF;
                                end else if (e_reg == ONE_VAL) begin
                                    res_reg <= u_signed;
                                end else begin
                                    e_reg      <= e_reg - ONE_VAL;
                                    ux_reg     <= mn_reg;
                                    uy_reg     <= u_lo;
                                    udiv_reg   <= 1'b0;
                                    ustart_reg <= 1'b1;
                                    state_reg  <= S_MULDIV;
                                end
                            end
                            default: begin
                                res_reg <= acc_reg;
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        m_valid_reg     <= 1'b1;
                        m_acc_value_reg <= RESULT_WIDTH'(res_reg);
                        m_status_reg    <= st_reg;
                        acc_reg         <= res_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_acc_value = m_acc_value_reg;
    assign m_status    = m_status_reg;

`ifndef ASSERT_OFF
    // Any error status must leave the accumulator as it was.
    a_error_keeps_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (st_reg != ST_OK)) |-> (res_reg == acc_reg))
        else $error("error transaction would change the accumulator");

    // Divide by zero can only come from divide or remainder.
    a_div0_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (st_reg == ST_DIV0)) |-> ((op_reg == OP_DIV) || (op_reg == OP_REM)))
        else $error("divide-by-zero status from a non-division operation");

    // Underflow can only come from add or subtract.
    a_unf_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (st_reg == ST_UNF)) |-> ((op_reg == OP_ADD) || (op_reg == OP_SUB)))
        else $error("underflow status from an operation that cannot underflow");

    // The accumulator changes only when a result is handed to the output.
    a_acc_only_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_load |=> $stable(acc_reg))
        else $error("accumulator changed outside result hand-over");

    // The shared unit only completes while the sequencer waits for it.
    a_unit_done_in_muldiv: assert property (@(posedge aclk) disable iff (!aresetn)
        u_sts.done |-> (state_reg == S_MULDIV))
        else $error("muldiv unit completed outside its wait state");
`endif

endmodule
